// ===== hdl/gww_pkg.sv =====
// Shared constants, payload types and field codes of the greedy word wrap core.
package gww_pkg;

	localparam int MAX_LINE_WIDTH = 16;
	localparam int WORD_DEPTH     = 24;

	localparam int CODE_W = 21;
	localparam int CW_W   = 2;
	localparam int CFG_W  = 5;
	localparam int LINE_W = $clog2(MAX_LINE_WIDTH + 1);
	localparam int WCOL_W = LINE_W + 1;
	localparam int SUM_W  = LINE_W + 2;
	localparam int ENT_W  = $clog2(WORD_DEPTH + 1);
	localparam int IDX_W  = $clog2(WORD_DEPTH);

	localparam logic [CODE_W-1:0] SPACE_CODE = CODE_W'(32);
	localparam logic [CFG_W-1:0]  LINE_WIDTH_RESET = CFG_W'(16);
	localparam logic [CW_W-1:0]   CW_WIDE = CW_W'(2);
	localparam logic [CW_W-1:0]   CW_BAD  = CW_W'(3);

	localparam logic KIND_GLYPH = 1'b0;
	localparam logic KIND_EOL   = 1'b1;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [CW_W-1:0]   char_width;
		logic              end_of_text;
	} gww_in_t;

	typedef struct packed {
		logic              kind;
		logic [CODE_W-1:0] glyph;
		logic              overflow;
		logic              last_of_run;
	} gww_out_t;

	typedef struct packed {
		logic [CFG_W-1:0] line_width;
	} gww_cfg_t;

	typedef struct packed {
		logic [CW_W-1:0]   cw;
		logic [CODE_W-1:0] code;
	} gww_entry_t;

endpackage

// ===== hdl/gww_chan_if.sv =====
// Valid/ready channel that carries one word of a given payload type.
interface gww_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/gww_out_stage.sv =====
// Output register that decouples the wrap sequencer from the result channel.
module gww_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gww_pkg::gww_out_t push_data,
	output logic              free,
	gww_chan_if.source        results
);
	import gww_pkg::*;

	logic     valid_q;
	gww_out_t data_q;

	// The register can take a new word when empty or when its word leaves now.
	assign free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (free && push) begin
			data_q <= push_data;
		end
	end

	assign results.valid = valid_q;
	assign results.data  = data_q;
endmodule

// ===== hdl/greedy_word_wrap_core.sv =====
// Top level of the greedy word wrap core: word buffer memory and wrap sequencer.
//
// The core wraps a stream of codepoints into lines of at most line_width
// columns (0 acts as 1, values above 16 act as 16). Each input word carries
// one codepoint with its column width, or marks the end of a text. A
// non-space character of a word that still fits on a line is written into
// the word buffer unless it is full, and the core stays ready, so the next
// character can follow directly. A space or an end of text that closes a
// buffered word is accepted; the sequencer then decides on a line break and
// separating space and streams out the buffered glyphs, one per cycle while
// the output register is free, as the buffer memory has one read port that
// delivers one entry per cycle. An end of text then passes through a state
// of its own for its final line end, also when no line end is due. A word
// that grows wider than a line is streamed out of the buffer the same way,
// and each of its later characters is placed by a state of its own.
// Results leave through an output register, so a stalled result channel
// holds the sequencer but does not lose or repeat a word. The line width
// register may be written only while no text is in progress in the core.
module greedy_word_wrap_core (
	input  logic       clk,
	input  logic       arst_n,
	gww_chan_if.sink   chars,
	gww_chan_if.sink   cfg,
	gww_chan_if.source results
);
	import gww_pkg::*;

	// One-hot sequencer states.
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LEAD  = 6'b000010,
		ST_OLEAD = 6'b000100,
		ST_GLYPH = 6'b001000,
		ST_NEW   = 6'b010000,
		ST_FINAL = 6'b100000
	} gww_state_t;

	gww_state_t        state_q, state_d;
	logic [CFG_W-1:0]  cfg_q;
	logic [ENT_W-1:0]  entries_q, entries_d;
	logic [WCOL_W-1:0] wcols_q, wcols_d;
	logic [LINE_W-1:0] lcols_q, lcols_d;
	logic              lglyph_q, lglyph_d;
	logic              any_line_q, any_line_d;
	logic              overlong_q, overlong_d;
	logic              in_spaces_q, in_spaces_d;
	logic              ovf_q, ovf_d;
	logic              eot_q, eot_d;
	logic              brk_mode_q, brk_mode_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [CODE_W-1:0] new_code_q, new_code_d;
	logic [CW_W-1:0]   new_cw_q, new_cw_d;

	// Word buffer and its registered read data.
	gww_entry_t        word_mem [WORD_DEPTH];
	gww_entry_t        rd_q;
	logic              mem_we;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	gww_entry_t        mem_wdata;

	logic [LINE_W-1:0] eff;
	logic [CW_W-1:0]   cw_in;
	logic              free;
	logic              push;
	logic              push_kind;
	logic [CODE_W-1:0] push_glyph;
	logic [CW_W-1:0]   push_cw;
	logic              push_last;
	logic              text_done;
	logic              last_entry;
	gww_out_t          push_data;

	// Effective line width, clamped into the supported range.
	always_comb begin
		if (cfg_q == '0) begin
			eff = LINE_W'(1);
		end else if (int'(cfg_q) > MAX_LINE_WIDTH) begin
			eff = LINE_W'(MAX_LINE_WIDTH);
		end else begin
			eff = LINE_W'(cfg_q);
		end
	end

	// A width code of three is treated as a double-width character.
	assign cw_in = (chars.data.char_width == CW_BAD) ? CW_WIDE : chars.data.char_width;

	assign chars.ready = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;

	assign last_entry = (ENT_W'(idx_q) + ENT_W'(1)) == entries_q;
	assign mem_wdata  = '{cw: cw_in, code: chars.data.code};

	// Sequencer: every state emits at most one result word per cycle, and
	// each break decision is taken again from the live line state, so after a
	// line end the next decision sees the emptied line before a glyph is placed.
	always_comb begin
		state_d     = state_q;
		entries_d   = entries_q;
		wcols_d     = wcols_q;
		lcols_d     = lcols_q;
		lglyph_d    = lglyph_q;
		any_line_d  = any_line_q;
		overlong_d  = overlong_q;
		in_spaces_d = in_spaces_q;
		ovf_d       = ovf_q;
		eot_d       = eot_q;
		brk_mode_d  = brk_mode_q;
		idx_d       = idx_q;
		new_code_d  = new_code_q;
		new_cw_d    = new_cw_q;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_raddr   = '0;
		push        = 1'b0;
		push_kind   = KIND_GLYPH;
		push_glyph  = '0;
		push_cw     = '0;
		push_last   = 1'b0;
		text_done   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (chars.valid) begin
					// Fetch the first buffered glyph in case a flush follows.
					mem_re     = 1'b1;
					mem_raddr  = '0;
					eot_d      = chars.data.end_of_text;
					new_code_d = chars.data.code;
					new_cw_d   = cw_in;
					idx_d      = '0;
					if (chars.data.end_of_text) begin
						in_spaces_d = 1'b0;
						if (overlong_q) begin
							overlong_d = 1'b0;
							state_d    = ST_FINAL;
						end else if (entries_q != '0) begin
							brk_mode_d = 1'b0;
							state_d    = ST_LEAD;
						end else begin
							state_d = ST_FINAL;
						end
					end else if (chars.data.code == SPACE_CODE) begin
						in_spaces_d = 1'b1;
						if (!in_spaces_q) begin
							if (overlong_q) begin
								overlong_d = 1'b0;
							end else if (entries_q != '0) begin
								brk_mode_d = 1'b0;
								state_d    = ST_LEAD;
							end
						end
					end else begin
						in_spaces_d = 1'b0;
						if (overlong_q) begin
							state_d = ST_NEW;
						end else if (SUM_W'(wcols_q) + SUM_W'(cw_in) > SUM_W'(eff)) begin
							// The word no longer fits any line: stream it out.
							brk_mode_d = 1'b1;
							state_d    = ST_OLEAD;
						end else if (int'(entries_q) < WORD_DEPTH) begin
							mem_we    = 1'b1;
							entries_d = entries_q + ENT_W'(1);
							wcols_d   = WCOL_W'(wcols_q + WCOL_W'(cw_in));
						end else begin
							ovf_d = 1'b1;
						end
					end
				end
			end
			ST_LEAD: begin
				// Closing a word: break the line if the word does not fit after
				// one space, else separate it from a line that has columns.
				if (lcols_q != '0 &&
				    SUM_W'(lcols_q) + SUM_W'(1) + SUM_W'(wcols_q) > SUM_W'(eff)) begin
					push      = free;
					push_kind = KIND_EOL;
				end else if (lcols_q != '0) begin
					push       = free;
					push_glyph = SPACE_CODE;
					push_cw    = CW_W'(1);
					if (free) begin
						state_d = ST_GLYPH;
					end
				end else begin
					state_d = ST_GLYPH;
				end
			end
			ST_OLEAD: begin
				if (lcols_q != '0) begin
					push      = free;
					push_kind = KIND_EOL;
				end else if (entries_q != '0) begin
					state_d = ST_GLYPH;
				end else begin
					state_d = ST_NEW;
				end
			end
			ST_GLYPH: begin
				if (brk_mode_q && lglyph_q &&
				    SUM_W'(lcols_q) + SUM_W'(rd_q.cw) > SUM_W'(eff)) begin
					push      = free;
					push_kind = KIND_EOL;
				end else if (free) begin
					push       = 1'b1;
					push_glyph = rd_q.code;
					push_cw    = rd_q.cw;
					push_last  = !brk_mode_q && last_entry && !eot_q;
					if (last_entry) begin
						if (brk_mode_q) begin
							state_d = ST_NEW;
						end else begin
							entries_d = '0;
							wcols_d   = '0;
							state_d   = eot_q ? ST_FINAL : ST_IDLE;
						end
					end else begin
						idx_d     = idx_q + IDX_W'(1);
						mem_re    = 1'b1;
						mem_raddr = idx_q + IDX_W'(1);
					end
				end
			end
			ST_NEW: begin
				if (lglyph_q && SUM_W'(lcols_q) + SUM_W'(new_cw_q) > SUM_W'(eff)) begin
					push      = free;
					push_kind = KIND_EOL;
				end else if (free) begin
					push       = 1'b1;
					push_glyph = new_code_q;
					push_cw    = new_cw_q;
					push_last  = 1'b1;
					entries_d  = '0;
					wcols_d    = '0;
					overlong_d = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_FINAL: begin
				// A text ends with a line end unless the line is empty and an
				// earlier line already ended.
				if (lglyph_q || !any_line_q) begin
					push      = free;
					push_kind = KIND_EOL;
					push_last = 1'b1;
					if (free) begin
						text_done = 1'b1;
						state_d   = ST_IDLE;
					end
				end else begin
					text_done = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (push) begin
			if (push_kind == KIND_EOL) begin
				lcols_d    = '0;
				lglyph_d   = 1'b0;
				any_line_d = 1'b1;
			end else begin
				lcols_d  = LINE_W'(SUM_W'(lcols_q) + SUM_W'(push_cw));
				lglyph_d = 1'b1;
			end
			if (push_last) begin
				ovf_d = 1'b0;
			end
		end
		if (text_done) begin
			lcols_d    = '0;
			lglyph_d   = 1'b0;
			any_line_d = 1'b0;
		end
	end

	assign push_data = '{
		kind:        push_kind,
		glyph:       push_glyph,
		overflow:    ovf_q,
		last_of_run: push_last
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= LINE_WIDTH_RESET;
			entries_q   <= '0;
			wcols_q     <= '0;
			lcols_q     <= '0;
			lglyph_q    <= 1'b0;
			any_line_q  <= 1'b0;
			overlong_q  <= 1'b0;
			in_spaces_q <= 1'b0;
			ovf_q       <= 1'b0;
			eot_q       <= 1'b0;
			brk_mode_q  <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q     <= state_d;
			entries_q   <= entries_d;
			wcols_q     <= wcols_d;
			lcols_q     <= lcols_d;
			lglyph_q    <= lglyph_d;
			any_line_q  <= any_line_d;
			overlong_q  <= overlong_d;
			in_spaces_q <= in_spaces_d;
			ovf_q       <= ovf_d;
			eot_q       <= eot_d;
			brk_mode_q  <= brk_mode_d;
			idx_q       <= idx_d;
			if (cfg.valid) begin
				cfg_q <= cfg.data.line_width;
			end
		end
	end

	// Character payload of the item in progress.
	always_ff @(posedge clk) begin
		new_code_q <= new_code_d;
		new_cw_q   <= new_cw_d;
	end

	// Word buffer: one write port and one read port with a registered output
	// that holds its word until the next read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			word_mem[entries_q[IDX_W-1:0]] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= word_mem[mem_raddr];
		end
	end

	gww_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.free      (free),
		.results   (results)
	);
endmodule

// ===== dv/tb_greedy_word_wrap_core.sv =====
// Self-checking testbench of the greedy word wrap core with a built-in line layout predictor.
`timescale 1ns / 1ps

module tb_greedy_word_wrap_core;
	import gww_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 3;
	// The core may still be passing through its final state after the last
	// result leaves, so every pause before a register write or the end of the
	// run first waits for the core to settle.
	localparam int SETTLE_CYCLES = 16;
	// The slowest correct run stays far below this: every word yields at most
	// 52 results, and every result stall burst is bounded.
	localparam int CYCLE_LIMIT   = 4000000;
	localparam int RESULT_CAP    = 52;
	localparam int PHASE_ITEMS   = 30;
	localparam int NUM_PHASES    = 8;
	localparam int PRINT_LIMIT   = 40;

	logic clk;
	logic arst_n;

	gww_chan_if #(.payload_t(gww_in_t))  chars_if ();
	gww_chan_if #(.payload_t(gww_cfg_t)) cfg_if ();
	gww_chan_if #(.payload_t(gww_out_t)) results_if ();

	greedy_word_wrap_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.cfg     (cfg_if),
		.results (results_if)
	);

	// Words waiting to be offered to the core, and the layout results that
	// the predictor has worked out but the core has not yet delivered.
	gww_in_t  pending_chars[$];
	gww_out_t expected_layout[$];
	gww_out_t step_layout[$];

	// Predictor state: a private copy of the word buffer, the line position
	// and the line width register.
	gww_entry_t word_buf[WORD_DEPTH];
	int         word_count;
	int         word_cols;
	int         line_cols;
	bit         line_has_glyph;
	bit         line_ended;
	bit         overlong;
	bit         in_space_run;
	bit         drop_pending;
	logic [CFG_W-1:0] width_reg;
	int         eff_width;

	// Run bookkeeping.
	int  cycle_count;
	int  mismatches;
	int  texts_queued;
	int  items_queued;
	int  items_taken;
	int  results_seen;
	int  line_ends_seen;
	int  overflow_seen;
	int  settings_used;
	int  phase_width;
	bit  idle_on;
	bit  char_taken;
	int  char_gap;
	int  result_stall;

	// ------------------------------------------------------------------
	// Clock and reset. Reset is asserted once and is released on a falling
	// edge so that it never races the rising edge.
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still outstanding",
				cycle_count, expected_layout.size());
			$display("tb_greedy_word_wrap_core: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Layout predictor. Each accepted input word is run through the same
	// greedy wrap decisions the core makes; the results of one word are
	// gathered first so that the final one can be tagged last_of_run.
	// ------------------------------------------------------------------
	function automatic void add_result(logic kind, logic [CODE_W-1:0] glyph);
		gww_out_t r;
		if (step_layout.size() >= RESULT_CAP)
			return;
		r.kind        = kind;
		r.glyph       = glyph;
		r.overflow    = drop_pending;
		r.last_of_run = 1'b0;
		step_layout.insert(step_layout.size(), r);
	endfunction

	function automatic void end_current_line();
		add_result(KIND_EOL, '0);
		line_cols      = 0;
		line_has_glyph = 1'b0;
		line_ended     = 1'b1;
	endfunction

	function automatic void place_glyph(logic [CODE_W-1:0] code, int cols);
		add_result(KIND_GLYPH, code);
		line_cols      += cols;
		line_has_glyph = 1'b1;
	endfunction

	// Inside an overlong word a line breaks between characters, but never
	// in front of the first glyph of a line.
	function automatic void place_with_break(logic [CODE_W-1:0] code, int cols);
		if (line_has_glyph && line_cols + cols > eff_width)
			end_current_line();
		place_glyph(code, cols);
	endfunction

	function automatic void flush_word();
		if (overlong) begin
			overlong = 1'b0;
		end else if (word_count > 0) begin
			// A line of only zero-width glyphs takes the word without a space.
			if (line_cols > 0 && line_cols + 1 + word_cols > eff_width)
				end_current_line();
			if (line_cols > 0)
				place_glyph(SPACE_CODE, 1);
			for (int k = 0; k < word_count; k++)
				place_glyph(word_buf[k].code, int'(word_buf[k].cw));
		end
		word_count = 0;
		word_cols  = 0;
	endfunction

	function automatic void predict_layout(gww_in_t item);
		int cols;
		cols = int'(item.char_width);
		if (item.char_width == CW_BAD)
			cols = int'(CW_WIDE);
		eff_width = int'(width_reg);
		if (eff_width < 1)
			eff_width = 1;
		if (eff_width > MAX_LINE_WIDTH)
			eff_width = MAX_LINE_WIDTH;
		step_layout.delete();

		if (item.end_of_text) begin
			flush_word();
			// An empty text still yields one line end.
			if (line_has_glyph || !line_ended)
				end_current_line();
			line_cols      = 0;
			line_has_glyph = 1'b0;
			line_ended     = 1'b0;
			in_space_run   = 1'b0;
		end else if (item.code == SPACE_CODE) begin
			if (!in_space_run)
				flush_word();
			in_space_run = 1'b1;
		end else begin
			in_space_run = 1'b0;
			if (overlong) begin
				place_with_break(item.code, cols);
			end else if (word_cols + cols > eff_width) begin
				// The word no longer fits any line: start it on a fresh line
				// and stream out what was buffered so far.
				if (line_cols > 0)
					end_current_line();
				for (int k = 0; k < word_count; k++)
					place_with_break(word_buf[k].code, int'(word_buf[k].cw));
				place_with_break(item.code, cols);
				word_count = 0;
				word_cols  = 0;
				overlong   = 1'b1;
			end else if (word_count < WORD_DEPTH) begin
				word_buf[word_count].code = item.code;
				word_buf[word_count].cw   = CW_W'(cols);
				word_count++;
				word_cols += cols;
			end else begin
				drop_pending = 1'b1;
			end
		end

		if (step_layout.size() > 0) begin
			step_layout[step_layout.size() - 1].last_of_run = 1'b1;
			drop_pending = 1'b0;
			foreach (step_layout[k])
				expected_layout.insert(expected_layout.size(), step_layout[k]);
		end
	endfunction

	// ------------------------------------------------------------------
	// Checking.
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got)
			report_mismatch($sformatf("result %0d field %s expected 0x%0h got 0x%0h",
				results_seen, name, want, got));
	endtask

	// Sampling at the rising edge: an accepted character is predicted first,
	// then any accepted result is compared with the oldest expectation.
	// Results come out of a register, so a result never belongs to a word
	// accepted at the same edge.
	always @(posedge clk) begin
		gww_out_t want;
		gww_out_t got;
		char_taken = arst_n && chars_if.valid && chars_if.ready;
		if (char_taken) begin
			items_taken++;
			predict_layout(chars_if.data);
		end
		if (arst_n && results_if.valid && results_if.ready) begin
			got = results_if.data;
			if (got.kind == KIND_EOL)
				line_ends_seen++;
			if (got.overflow)
				overflow_seen++;
			if (expected_layout.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d glyph 0x%0h",
					got.kind, got.glyph));
			end else begin
				want = expected_layout.pop_front();
				check_field("kind", want.kind, got.kind);
				check_field("glyph", want.glyph, got.glyph);
				check_field("overflow", want.overflow, got.overflow);
				check_field("last_of_run", want.last_of_run, got.last_of_run);
			end
			results_seen++;
		end
	end

	// ------------------------------------------------------------------
	// Character driver. It offers the next pending word at the falling edge
	// once the previous one was taken, and inserts random idle bursts while
	// idling is enabled.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!chars_if.valid || char_taken)) begin
			if (char_gap > 0) begin
				char_gap--;
				chars_if.valid <= 1'b0;
			end else if (pending_chars.size() == 0) begin
				chars_if.valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				char_gap = $urandom_range(1, 14) - 1;
				chars_if.valid <= 1'b0;
			end else begin
				chars_if.data  <= pending_chars.pop_front();
				chars_if.valid <= 1'b1;
			end
		end
	end

	// Result sink: ready, with stall bursts of the idle bursts' length range while idling is on.
	always @(negedge clk) begin
		if (arst_n) begin
			if (result_stall > 0) begin
				result_stall--;
				results_if.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				result_stall = $urandom_range(1, 14) - 1;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	task automatic queue_item(input bit eot, input logic [CODE_W-1:0] code,
			input logic [CW_W-1:0] cw);
		pending_chars.insert(pending_chars.size(),
			gww_in_t'{code: code, char_width: cw, end_of_text: eot});
		items_queued++;
		if (eot)
			texts_queued++;
	endtask

	function automatic logic [CW_W-1:0] rand_width();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return CW_W'(0);
		if (pick <= 10)
			return CW_W'(1);
		if (pick <= 13)
			return CW_WIDE;
		return CW_BAD;
	endfunction

	// Any non-space codepoint, including values beyond the Unicode range.
	function automatic logic [CODE_W-1:0] rand_glyph();
		logic [CODE_W-1:0] code;
		case ($urandom_range(0, 3))
			0: code = CODE_W'($urandom_range(33, 126));
			1: code = CODE_W'($urandom_range(0, (1 << CODE_W) - 1));
			2: code = CODE_W'($urandom_range(16'h4E00, 16'h9FFF));
			default: code = CODE_W'($urandom_range(0, 31));
		endcase
		if (code == SPACE_CODE)
			code = CODE_W'(33);
		return code;
	endfunction

	task automatic queue_spaces(input int lo, input int hi);
		repeat ($urandom_range(lo, hi))
			queue_item(1'b0, SPACE_CODE, CW_W'($urandom_range(0, 3)));
	endtask

	// One random text: mostly ordinary words, some wider than the line,
	// now and then a zero-width word long enough to overrun the buffer.
	// The end-of-text word carries random code and width, space included.
	task automatic queue_random_text();
		int words;
		int len;
		int pick;
		logic [CODE_W-1:0] eot_code;
		words = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0)
			queue_spaces(1, 3);
		for (int w = 0; w < words; w++) begin
			pick = $urandom_range(0, 24);
			if (pick == 0) begin
				len = WORD_DEPTH + $urandom_range(1, 3);
				repeat (len)
					queue_item(1'b0, rand_glyph(), CW_W'(0));
			end else begin
				if (pick <= 4)
					len = $urandom_range(phase_width + 1, phase_width + 6);
				else
					len = $urandom_range(1, 5);
				repeat (len)
					queue_item(1'b0, rand_glyph(), rand_width());
			end
			if (w < words - 1 || $urandom_range(0, 1) == 1)
				queue_spaces(1, 3);
		end
		eot_code = ($urandom_range(0, 1) == 1) ? SPACE_CODE : rand_glyph();
		queue_item(1'b1, eot_code, CW_W'($urandom_range(0, 3)));
	endtask

	// Waits until every queued word was taken and every result has arrived,
	// then lets the core settle.
	task automatic wait_drained();
		while (pending_chars.size() != 0 || chars_if.valid || expected_layout.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Line width writes happen only while the core holds no text.
	task automatic write_line_width(input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_if.data.line_width <= value;
		cfg_if.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		width_reg = value;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		settings_used++;
		phase_width = (value < 1) ? 1 : ((value > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : value);
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		logic [CFG_W-1:0] widths[NUM_PHASES];
		int phase_start;

		chars_if.valid   = 1'b0;
		chars_if.data    = '0;
		cfg_if.valid     = 1'b0;
		cfg_if.data      = '0;
		results_if.ready = 1'b0;
		width_reg        = LINE_WIDTH_RESET;
		word_count       = 0;
		word_cols        = 0;
		line_cols        = 0;
		line_has_glyph   = 1'b0;
		line_ended       = 1'b0;
		overlong         = 1'b0;
		in_space_run     = 1'b0;
		drop_pending     = 1'b0;
		idle_on          = 1'b1;
		char_gap         = 0;
		result_stall     = 0;
		phase_width      = MAX_LINE_WIDTH;

		wait (arst_n === 1'b1);
		repeat (2) @(posedge clk);

		// Directed texts on a four-column line. An empty text; leading
		// spaces and space runs that collapse, with a word that no longer
		// fits after its space; a zero-width glyph that a later word joins
		// without a space; then a word that outgrows the line and breaks
		// between characters, one of them with width code three.
		write_line_width(CFG_W'(4));
		queue_item(1'b1, '0, '0);
		queue_item(1'b0, SPACE_CODE, CW_W'(1));
		queue_item(1'b0, SPACE_CODE, CW_W'(0));
		queue_item(1'b0, CODE_W'("a"), CW_W'(1));
		queue_item(1'b0, CODE_W'("b"), CW_WIDE);
		queue_item(1'b0, SPACE_CODE, CW_W'(1));
		queue_item(1'b0, SPACE_CODE, CW_W'(1));
		queue_item(1'b0, CODE_W'("c"), CW_W'(1));
		queue_item(1'b0, SPACE_CODE, CW_W'(1));
		queue_item(1'b1, CODE_W'("x"), CW_W'(1));
		queue_item(1'b0, CODE_W'(0), CW_W'(0));
		queue_item(1'b0, SPACE_CODE, CW_W'(1));
		queue_item(1'b0, CODE_W'("y"), CW_W'(1));
		queue_item(1'b1, SPACE_CODE, CW_WIDE);
		queue_item(1'b0, CODE_W'("p"), CW_W'(1));
		queue_item(1'b0, CODE_W'("q"), CW_W'(1));
		queue_item(1'b0, CODE_W'("r"), CW_W'(1));
		queue_item(1'b0, CODE_W'("s"), CW_W'(1));
		queue_item(1'b0, CODE_W'("t"), CW_W'(1));
		queue_item(1'b0, CODE_W'("w"), CW_BAD);
		queue_item(1'b1, '1, CW_BAD);
		wait_drained();

		// On a one-column line two wide characters each sit alone, and the
		// largest code value goes through as a zero-width glyph.
		write_line_width(CFG_W'(1));
		queue_item(1'b0, CODE_W'("m"), CW_WIDE);
		queue_item(1'b0, CODE_W'("n"), CW_WIDE);
		queue_item(1'b0, '1, CW_W'(0));
		queue_item(1'b1, SPACE_CODE, CW_BAD);
		wait_drained();

		// Random phases over several line widths, out-of-range ones and
		// both ends of the register among them. The fourth phase runs
		// without idling, and so does the last one.
		widths = '{CFG_W'(31), CFG_W'(1), CFG_W'(0), CFG_W'(16), CFG_W'(17), CFG_W'(2),
			CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(1, 16))};
		for (int p = 0; p < NUM_PHASES; p++) begin
			idle_on = !(p == 3 || p == NUM_PHASES - 1);
			write_line_width(widths[p]);
			phase_start = items_queued;
			while (items_queued - phase_start < PHASE_ITEMS)
				queue_random_text();
			wait_drained();
		end

		$display("covered %0d texts and %0d input words over %0d line width settings",
			texts_queued, items_taken, settings_used);
		$display("checked %0d results: %0d line ends, %0d flagged overflow, %0d mismatches",
			results_seen, line_ends_seen, overflow_seen, mismatches);
		if (mismatches == 0)
			$display("tb_greedy_word_wrap_core: PASS");
		else
			$display("tb_greedy_word_wrap_core: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/gww_pkg.sv
hdl/gww_chan_if.sv
hdl/gww_out_stage.sv
hdl/greedy_word_wrap_core.sv
dv/tb_greedy_word_wrap_core.sv
